### src/rational_arithmetic_unit_macros.svh
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_macros
// Assertion macros for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// check that a implies b on the next edge
`define RAU_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
// check that a implies b on the same edge
`define RAU_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`endif

### src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
  localparam int VALUE_WIDTH = 32;
  localparam int MAG_W = 2 * VALUE_WIDTH;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_CMP = 3'd4, OP_TRUNC = 3'd5, OP_RED = 3'd6, OP_NONE = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ZDEN = 2'd1, ST_DIVZ = 2'd2, ST_OVF = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD, S_DIVN, S_DIVD, S_CHECK, S_DONE
  } state_t;
endpackage

### src/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add, subtract, multiply, divide, compare, truncate and reduce of
// signed fractions, with gcd reduction on a shared iterative datapath.
// ----------------------------------------------------------------------------
// channel | handshake     | payload
// in      | start / busy  | in_operation, in_a_num, in_a_den, in_b_num, in_b_den
// out     | out_valid     | out_result_num, out_result_den, flags, out_status
// Setup runs through S_MUL1, S_MUL2, S_MUL3 and S_COMB, then Euclid on the single
// shift/subtract divider, then the two exact divisions S_DIVN and S_DIVD and the
// finishing states S_CHECK and S_DONE; no new item is taken until the last is done.
// Short paths (errors, zero, compare, no-op) go from S_COMB straight to S_DONE.
// busy is high from accept until the strobe; the receiver cannot stall.
// Reset (synchronous, active low) returns the sequencer to idle.
module rational_arithmetic_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_operation,
  input  logic signed [31:0]       in_a_num,
  input  logic signed [31:0]       in_a_den,
  input  logic signed [31:0]       in_b_num,
  input  logic signed [31:0]       in_b_den,
  output logic                     out_valid,
  output logic signed [31:0]       out_result_num,
  output logic [30:0]              out_result_den,
  output logic                     out_less,
  output logic                     out_equal,
  output logic                     out_greater,
  output logic [1:0]               out_status
);
  import rau_pkg::*;
`include "rational_arithmetic_unit_macros.svh"

  localparam int W = VALUE_WIDTH;
  localparam int CW = $clog2(MAG_W + 1);

  state_t state_r, state_nxt;
  op_t op_r;
  logic [W-1:0] an_m_r, ad_m_r, bn_m_r, bd_m_r;
  logic n1_neg_r, n2_neg_r;
  logic [MAG_W-1:0] p1_r, p2_r, ga_r, gb_r, g_r, q_r, rem_r;
  logic p1_neg_r, p2_neg_r, rn_neg_r;
  logic [MAG_W-1:0] nm_r, dm_r;
  logic [CW-1:0] cnt_r;
  logic div_run_r;
  logic [MAG_W-1:0] dvd_r, dvs_r;
  logic [1:0] status_r;
  logic lt_r, eq_r, gt_r;
  logic [31:0] num_o_r;
  logic [30:0] den_o_r;
  logic valid_r;

  // operand unpacking
  function automatic logic [W-1:0] mag_of(input logic [31:0] v);
    logic [W-1:0] x;
    x = v[W-1:0];
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  logic [W-1:0] an_m, ad_m, bn_m, bd_m;
  logic n1_neg, n2_neg;
  assign an_m = mag_of(in_a_num);
  assign ad_m = mag_of(in_a_den);
  assign bn_m = mag_of(in_b_num);
  assign bd_m = mag_of(in_b_den);
  assign n1_neg = (in_a_num[W-1] ^ in_a_den[W-1]) && (an_m != '0);
  assign n2_neg = (in_b_num[W-1] ^ in_b_den[W-1]) && (bn_m != '0);

  // the one shared multiplier, operand chosen by state
  logic [W-1:0] mx, my;
  logic [MAG_W-1:0] prod;
  always_comb begin
    mx = an_m_r; my = bd_m_r;
    unique case (state_r)
      S_MUL1: begin
        mx = an_m_r;
        my = (op_r == OP_MUL) ? bn_m_r : (op_r == OP_DIV) ? bd_m_r :
             (op_r == OP_RED || op_r == OP_TRUNC) ? W'(1) : bd_m_r;
      end
      S_MUL2: begin
        mx = (op_r == OP_DIV) ? ad_m_r : bn_m_r;
        my = (op_r == OP_DIV) ? bn_m_r : ad_m_r;
      end
      S_MUL3: begin
        mx = ad_m_r;
        my = (op_r == OP_MUL) ? bn_m_r : bd_m_r;
        if (op_r == OP_MUL) my = bd_m_r;
        if (op_r == OP_DIV) begin mx = ad_m_r; my = bn_m_r; end
      end
      default: ;
    endcase
  end
  assign prod = MAG_W'(mx) * MAG_W'(my);

  // shared restoring divider step
  logic [MAG_W:0] trial;
  logic [MAG_W-1:0] rem_sh;
  assign rem_sh = {rem_r[MAG_W-2:0], dvd_r[MAG_W-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs_r};

  // signed add of the cross products
  logic t_neg;
  logic [MAG_W-1:0] sum_m;
  logic sum_neg;
  always_comb begin
    t_neg = (op_r == OP_SUB) ? (~p2_neg_r && p2_r != '0) : p2_neg_r;
    if (p1_neg_r == t_neg) begin
      sum_m = p1_r + p2_r; sum_neg = p1_neg_r;
    end else if (p1_r >= p2_r) begin
      sum_m = p1_r - p2_r; sum_neg = p1_neg_r;
    end else begin
      sum_m = p2_r - p1_r; sum_neg = t_neg;
    end
    if (sum_m == '0) sum_neg = 1'b0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_MUL3;
      S_MUL3:  state_nxt = S_COMB;
      S_COMB:  state_nxt = (status_r != ST_OK || op_r == OP_CMP || op_r == OP_NONE ||
                            nm_r == '0) ? S_DONE : S_GCD;
      S_GCD:   if (!div_run_r && gb_r == '0) state_nxt = S_DIVN;
      S_DIVN:  if (div_run_r && cnt_r == CW'(1)) state_nxt = S_DIVD;
      S_DIVD:  if (div_run_r && cnt_r == CW'(1)) state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      div_run_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_r == S_DONE);
      unique case (state_r)
        S_IDLE: if (start) begin
          op_r <= op_t'(in_operation);
          an_m_r <= an_m; ad_m_r <= ad_m; bn_m_r <= bn_m; bd_m_r <= bd_m;
          n1_neg_r <= n1_neg; n2_neg_r <= n2_neg;
          lt_r <= 1'b0; eq_r <= 1'b0; gt_r <= 1'b0;
          if (in_operation <= OP_CMP && (ad_m == '0 || bd_m == '0)) status_r <= ST_ZDEN;
          else if ((in_operation == OP_TRUNC || in_operation == OP_RED) && ad_m == '0)
            status_r <= ST_ZDEN;
          else if (in_operation == OP_DIV && bn_m == '0) status_r <= ST_DIVZ;
          else status_r <= ST_OK;
        end
        S_MUL1: begin
          p1_r <= prod;
          p1_neg_r <= (op_r == OP_MUL) ? ((n1_neg_r ^ n2_neg_r) && prod != '0) : n1_neg_r;
        end
        S_MUL2: begin
          p2_r <= prod;
          p2_neg_r <= (op_r == OP_DIV) ? 1'b0 : n2_neg_r;
        end
        S_COMB: ;
        default: ;
      endcase
      // last multiply: form numerator/denominator by op
      if (state_r == S_MUL3) begin
        unique case (op_r)
          OP_ADD, OP_SUB: begin nm_r <= sum_m; rn_neg_r <= sum_neg; end
          OP_MUL: begin nm_r <= p1_r; rn_neg_r <= p1_neg_r; end
          OP_DIV: begin nm_r <= p1_r; rn_neg_r <= (n1_neg_r ^ n2_neg_r) && p1_r != '0; end
          OP_CMP: begin
            nm_r <= '0; rn_neg_r <= 1'b0;
            if (status_r == ST_OK) begin
              if (p1_neg_r != p2_neg_r) begin
                lt_r <= p1_neg_r; gt_r <= ~p1_neg_r;
              end else if (p1_r == p2_r) eq_r <= 1'b1;
              else if (p1_neg_r) begin lt_r <= p1_r > p2_r; gt_r <= p1_r < p2_r; end
              else begin lt_r <= p1_r < p2_r; gt_r <= p1_r > p2_r; end
            end
          end
          OP_TRUNC, OP_RED: begin nm_r <= p1_r; rn_neg_r <= n1_neg_r; end
          default: begin nm_r <= '0; rn_neg_r <= 1'b0; end
        endcase
        dm_r <= (op_r == OP_TRUNC || op_r == OP_RED) ? MAG_W'(ad_m_r) : prod;
      end
      if (state_r == S_COMB) begin
        // truncate: gcd stage replaced by gb=0 so divide by den directly
        ga_r <= (op_r == OP_TRUNC) ? MAG_W'(1) : nm_r;
        gb_r <= (op_r == OP_TRUNC) ? '0 : dm_r;
        div_run_r <= 1'b0;
      end
      // Euclid: ga mod gb on the shared divider
      if (state_r == S_GCD) begin
        if (!div_run_r) begin
          if (gb_r == '0) begin
            g_r <= ga_r;
            dvd_r <= nm_r; dvs_r <= (op_r == OP_TRUNC) ? dm_r : ga_r;
            rem_r <= '0; cnt_r <= CW'(MAG_W); div_run_r <= 1'b1;
          end else begin
            dvd_r <= ga_r; dvs_r <= gb_r; rem_r <= '0;
            cnt_r <= CW'(MAG_W); div_run_r <= 1'b1;
          end
        end else begin
          rem_r <= trial[MAG_W] ? rem_sh : trial[MAG_W-1:0];
          dvd_r <= {dvd_r[MAG_W-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            ga_r <= gb_r;
            gb_r <= trial[MAG_W] ? rem_sh : trial[MAG_W-1:0];
            div_run_r <= 1'b0;
          end
        end
      end
      // exact divisions; quotient bits shift into dvd
      if (state_r == S_DIVN || state_r == S_DIVD) begin
        if (state_r == S_DIVN && cnt_r == CW'(1)) begin
          q_r <= {dvd_r[MAG_W-2:0], ~trial[MAG_W]};
          dvd_r <= dm_r; dvs_r <= g_r; rem_r <= '0; cnt_r <= CW'(MAG_W);
        end else begin
          rem_r <= trial[MAG_W] ? rem_sh : trial[MAG_W-1:0];
          dvd_r <= {dvd_r[MAG_W-2:0], ~trial[MAG_W]};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            dm_r <= {dvd_r[MAG_W-2:0], ~trial[MAG_W]};
            nm_r <= q_r;
            div_run_r <= 1'b0;
          end
        end
      end
      // range checks
      if (state_r == S_CHECK) begin
        if (op_r == OP_TRUNC) begin
          if (nm_r == '0) rn_neg_r <= 1'b0;
          if (nm_r > (rn_neg_r && nm_r != '0 ? (MAG_W'(1) << (W-1))
                                             : ((MAG_W'(1) << (W-1)) - 1'b1)))
            status_r <= ST_OVF;
          dm_r <= MAG_W'(1);
        end else if (dm_r > ((MAG_W'(1) << (W-1)) - 1'b1) ||
                     nm_r > (rn_neg_r ? (MAG_W'(1) << (W-1))
                                      : ((MAG_W'(1) << (W-1)) - 1'b1)))
          status_r <= ST_OVF;
      end
    end
  end

  // truncate runs with g=1, so nm already holds the quotient; den forced to 1
  logic [MAG_W-1:0] num_m;
  assign num_m = (rn_neg_r && nm_r != '0) ? (~nm_r + 1'b1) : nm_r;

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      if (status_r != ST_OK || op_r == OP_CMP || op_r == OP_NONE || nm_r == '0) begin
        num_o_r <= '0; den_o_r <= 31'd1;
      end else begin
        num_o_r <= num_m[31:0];
        den_o_r <= (op_r == OP_TRUNC) ? 31'd1 : dm_r[30:0];
      end
      out_less <= (status_r == ST_OK) && lt_r;
      out_equal <= (status_r == ST_OK) && eq_r;
      out_greater <= (status_r == ST_OK) && gt_r;
      out_status <= status_r;
    end
  end

  assign out_valid = valid_r;
  assign out_result_num = num_o_r;
  assign out_result_den = den_o_r;

  // checks
  `RAU_ASSERT_NEXT(a_done_strobe, clk, rst_n, state_r == S_DONE, out_valid)
  `RAU_ASSERT_NOW(a_busy_no_strobe, clk, rst_n, out_valid, !busy || state_r == S_MUL1)
  `RAU_ASSERT_NOW(a_flags_onehot, clk, rst_n, out_valid,
                  $onehot0({out_less, out_equal, out_greater}))
endmodule

### tb/rational_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Self-checking testbench: drives fraction operations through the start/busy
// port, predicts each reduced result in the testbench and compares it, field
// by field, with every out_valid beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  typedef struct {
    op_t         op;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } frac_req_t;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        lt;
    logic        eq;
    logic        gt;
    status_t     status;
  } frac_res_t;

  localparam int WATCHDOG_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_operation = '0;
  logic [31:0] in_a_num = '0;
  logic [31:0] in_a_den = '0;
  logic [31:0] in_b_num = '0;
  logic [31:0] in_b_den = '0;
  logic        out_valid;
  logic [31:0] out_result_num;
  logic [30:0] out_result_den;
  logic        out_less;
  logic        out_equal;
  logic        out_greater;
  logic [1:0]  out_status;

  frac_req_t   pending_reqs[$];
  frac_res_t   expected_results[$];
  int          err_count = 0;
  int          idle_cycles = 0;
  bit          quiet_phase = 1'b0;
  bit          hold_drain = 1'b0;
  bit          all_sent = 1'b0;

  always #1 clk = ~clk;

  rational_arithmetic_unit i_dut (
    .clk, .rst_n, .start, .busy, .in_operation,
    .in_a_num, .in_a_den, .in_b_num, .in_b_den,
    .out_valid, .out_result_num, .out_result_den,
    .out_less, .out_equal, .out_greater, .out_status
  );

  // signed value to sign + magnitude
  function automatic void split_sign(input logic [31:0] v, output bit neg,
                                     output logic [63:0] mag);
    neg = v[31];
    mag = neg ? 64'(-$signed({1'b1, v})) : {32'd0, v};
    if (neg) mag = 64'h1_0000_0000 - {32'd0, v};
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // reduce n/d; returns overflow
  function automatic bit reduce_frac(input bit nneg, input logic [63:0] nmag,
                                     input logic [63:0] dmag,
                                     output logic [31:0] num, output logic [30:0] den);
    logic [63:0] g, nm, dm;
    num = '0;
    den = 31'd1;
    if (nmag == 0) return 1'b0;
    g = gcd64(nmag, dmag);
    nm = nmag / g;
    dm = dmag / g;
    if (dm > 64'h7FFF_FFFF) return 1'b1;
    if (nneg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF) return 1'b1;
    num = nneg ? 32'(-nm) : nm[31:0];
    den = dm[30:0];
    return 1'b0;
  endfunction

  // signed add of sign-magnitude pairs
  function automatic void sm_add(input bit xn, input logic [63:0] xm, input bit yn,
                                 input logic [63:0] ym, output bit rn,
                                 output logic [63:0] rm);
    if (xn == yn) begin
      rm = xm + ym; rn = xn;
    end else if (xm >= ym) begin
      rm = xm - ym; rn = xn;
    end else begin
      rm = ym - xm; rn = yn;
    end
    if (rm == 0) rn = 1'b0;
  endfunction

  function automatic frac_res_t predict_fraction(input frac_req_t r);
    frac_res_t   res;
    bit          an_s, ad_s, bn_s, bd_s, n1s, n2s, ts, ss, ps, qs, ovf;
    logic [63:0] an, ad, bn, bd, t, s, p, q, u, v;
    res = '{num: '0, den: 31'd1, lt: 0, eq: 0, gt: 0, status: ST_OK};
    ovf = 1'b0;
    split_sign(r.a_num, an_s, an);
    split_sign(r.a_den, ad_s, ad);
    split_sign(r.b_num, bn_s, bn);
    split_sign(r.b_den, bd_s, bd);
    n1s = (an != 0) && (an_s != ad_s);
    n2s = (bn != 0) && (bn_s != bd_s);
    if (r.op <= OP_CMP && (ad == 0 || bd == 0)) begin
      res.status = ST_ZDEN;
    end else if ((r.op == OP_TRUNC || r.op == OP_RED) && ad == 0) begin
      res.status = ST_ZDEN;
    end else if (r.op == OP_DIV && bn == 0) begin
      res.status = ST_DIVZ;
    end else begin
      case (r.op)
        OP_ADD, OP_SUB: begin
          t = bn * ad;
          ts = (t != 0) && (n2s ^ (r.op == OP_SUB));
          p = an * bd;
          ps = (p != 0) && n1s;
          sm_add(ps, p, ts, t, ss, s);
          ovf = reduce_frac(ss, s, ad * bd, res.num, res.den);
        end
        OP_MUL: begin
          p = an * bn;
          ovf = reduce_frac((p != 0) && (n1s != n2s), p, ad * bd, res.num, res.den);
        end
        OP_DIV: begin
          p = an * bd;
          ovf = reduce_frac((p != 0) && (n1s != n2s), p, ad * bn, res.num, res.den);
        end
        OP_CMP: begin
          u = an * bd;
          v = bn * ad;
          ps = (u != 0) && n1s;
          qs = (v != 0) && n2s;
          if (ps != qs) begin
            res.lt = ps; res.gt = !ps;
          end else if (u == v) begin
            res.eq = 1'b1;
          end else begin
            res.lt = ps ? (u > v) : (u < v);
            res.gt = !res.lt;
          end
        end
        OP_TRUNC: begin
          q = an / ad;
          qs = n1s && q != 0;
          if (qs ? q > 64'h8000_0000 : q > 64'h7FFF_FFFF) ovf = 1'b1;
          else res.num = qs ? 32'(-q) : q[31:0];
        end
        OP_RED: ovf = reduce_frac(n1s, an, ad, res.num, res.den);
        default: ;
      endcase
    end
    if (ovf) res.status = ST_OVF;
    if (res.status != ST_OK) begin
      res.num = '0; res.den = 31'd1; res.lt = 0; res.eq = 0; res.gt = 0;
    end
    return res;
  endfunction

  // pick a random operand value, weighted toward small and edge values
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'd0;
      3, 4:    return $urandom;
      5:       return 32'($signed($urandom_range(0, 40000)) - 20000);
      default: return 32'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  function automatic frac_req_t rand_req();
    frac_req_t r;
    r.op = op_t'($urandom_range(0, 7));
    r.a_num = rand_operand();
    r.a_den = rand_operand();
    r.b_num = rand_operand();
    r.b_den = rand_operand();
    // zero denominators are interesting but should not dominate
    if (r.a_den == 0 && $urandom_range(0, 3) != 0) r.a_den = 32'd1;
    if (r.b_den == 0 && $urandom_range(0, 3) != 0) r.b_den = 32'hFFFF_FFFF;
    return r;
  endfunction

  // directed then random stimulus
  initial begin
    frac_req_t r;
    pending_reqs.push_back('{OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3});
    pending_reqs.push_back('{OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2});
    pending_reqs.push_back('{OP_MUL, 32'hFFFF_FFFE, 32'd4, 32'd3, 32'hFFFF_FFFA});
    pending_reqs.push_back('{OP_DIV, 32'd3, 32'd4, 32'hFFFF_FFFF, 32'd2});
    pending_reqs.push_back('{OP_CMP, 32'd1, 32'd3, 32'd2, 32'd6});
    pending_reqs.push_back('{OP_CMP, 32'hFFFF_FFFF, 32'd2, 32'd1, 32'd2});
    pending_reqs.push_back('{OP_CMP, 32'd5, 32'hFFFF_FFFF, 32'd0, 32'd7});
    pending_reqs.push_back('{OP_TRUNC, 32'hFFFF_FFF9, 32'd2, 32'd0, 32'd0});
    pending_reqs.push_back('{OP_RED, 32'd12, 32'hFFFF_FFF8, 32'd0, 32'd0});
    pending_reqs.push_back('{OP_NONE, 32'd5, 32'd0, 32'd1, 32'd0});
    // zero denominators
    pending_reqs.push_back('{OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1});
    pending_reqs.push_back('{OP_CMP, 32'd1, 32'd1, 32'd1, 32'd0});
    pending_reqs.push_back('{OP_RED, 32'd1, 32'd0, 32'd1, 32'd0});
    pending_reqs.push_back('{OP_TRUNC, 32'd7, 32'd3, 32'd1, 32'd0});
    // division by zero fraction, and zero-den checked first
    pending_reqs.push_back('{OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5});
    pending_reqs.push_back('{OP_DIV, 32'd1, 32'd2, 32'd0, 32'd0});
    // overflow cases
    pending_reqs.push_back('{OP_TRUNC, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1});
    pending_reqs.push_back('{OP_RED, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1});
    pending_reqs.push_back('{OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1});
    pending_reqs.push_back('{OP_ADD, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE});
    pending_reqs.push_back('{OP_SUB, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1});
    // extremes that still fit
    pending_reqs.push_back('{OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF});
    pending_reqs.push_back('{OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF});
    pending_reqs.push_back('{OP_ADD, 32'd0, 32'h8000_0000, 32'd0, 32'd3});
    for (int i = 0; i < 1030; i++) begin
      r = rand_req();
      pending_reqs.push_back(r);
    end
  end

  // reset
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: start held until accepted (start && !busy)
  always @(posedge clk) begin
    frac_req_t r;
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(predict_fraction('{op_t'(in_operation), in_a_num,
                                                      in_a_den, in_b_num, in_b_den}));
      end
      if (!(start && busy)) begin
        // pause once mid-run until everything has drained
        if (pending_reqs.size() == 500 && !hold_drain && expected_results.size() != 0)
          hold_drain = 1'b0;
        if (pending_reqs.size() == 500 && expected_results.size() == 0)
          hold_drain = 1'b1;
        if (pending_reqs.size() == 600) quiet_phase = 1'b1;
        if (pending_reqs.size() == 300) quiet_phase = 1'b0;
        if (pending_reqs.size() == 0) begin
          start <= 1'b0;
          all_sent = 1'b1;
        end else if ((pending_reqs.size() == 500 && !hold_drain) ||
                     (!quiet_phase && $urandom_range(0, 99) < 6)) begin
          start <= 1'b0;
        end else begin
          r = pending_reqs.pop_front();
          start <= 1'b1;
          in_operation <= r.op;
          in_a_num <= r.a_num;
          in_a_den <= r.a_den;
          in_b_num <= r.b_num;
          in_b_den <= r.b_den;
        end
      end
    end
  end

  // monitor: compare each out_valid beat with the oldest expectation
  always @(posedge clk) begin
    frac_res_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat");
        err_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_result_num !== exp_res.num) begin
          $error("result_num exp %h got %h", exp_res.num, out_result_num); err_count++;
        end
        if (out_result_den !== exp_res.den) begin
          $error("result_den exp %h got %h", exp_res.den, out_result_den); err_count++;
        end
        if (out_less !== exp_res.lt) begin
          $error("less exp %b got %b", exp_res.lt, out_less); err_count++;
        end
        if (out_equal !== exp_res.eq) begin
          $error("equal exp %b got %b", exp_res.eq, out_equal); err_count++;
        end
        if (out_greater !== exp_res.gt) begin
          $error("greater exp %b got %b", exp_res.gt, out_greater); err_count++;
        end
        if (out_status !== exp_res.status) begin
          $error("status exp %0d got %0d", exp_res.status, out_status); err_count++;
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[rational_arithmetic_unit] ERROR");
      $finish;
    end
  end

  initial begin
    wait (all_sent);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0)
      $display("[rational_arithmetic_unit] OK");
    else
      $display("[rational_arithmetic_unit] ERROR");
    $finish;
  end
endmodule
